/* sv/sbc_pkg.sv */
// Shared types, round constants and mixing functions for the SHA-256 block compressor.
package sbc_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word      word;
        logic [3:0] idx;
        logic       start;
        logic       last;
        logic       final_blk;
    } t_entry;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;

    localparam t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_s0(input t_word x);
        big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_s1(input t_word x);
        big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_s0(input t_word x);
        small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_s1(input t_word x);
        small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* sv/sbc_front.sv */
// Front end: accepts message words, tags block position and flags, queues them.
module sbc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sbc_pkg::t_word i_message_word,
    input  logic           i_start_message,
    input  logic           i_final_block,
    output logic           o_entry_valid,
    output sbc_pkg::t_entry o_entry,
    input  logic           i_pop
);
    import sbc_pkg::*;

    t_entry             r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_fill;
    logic [3:0]         r_count;
    logic               r_final_pend;

    logic       push;
    logic       pop;
    logic [3:0] idx;
    logic       fin_blk;
    t_entry     entry;

    assign o_stall       = (r_fill == (FIFO_AW+1)'(FIFO_DEPTH));
    assign push          = i_valid && !o_stall;
    assign o_entry_valid = (r_fill != '0);
    assign pop           = i_pop && o_entry_valid;
    assign o_entry       = r_fifo[r_rd_ptr];

    always_comb begin
        idx             = i_start_message ? 4'd0 : r_count;
        fin_blk         = i_final_block || (!i_start_message && r_final_pend);
        entry.word      = i_message_word;
        entry.idx       = idx;
        entry.start     = i_start_message;
        entry.last      = &idx;
        entry.final_blk = fin_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill       <= '0;
            r_count      <= '0;
            r_final_pend <= 1'b0;
        end else begin
            if (push) begin
                r_fifo[r_wr_ptr] <= entry;
                r_wr_ptr         <= r_wr_ptr + FIFO_AW'(1);
                r_count          <= entry.last ? 4'd0 : idx + 4'd1;
                r_final_pend     <= entry.last ? 1'b0 : fin_blk;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (FIFO_AW+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (FIFO_AW+1)'(1);
            end
        end
    end

endmodule

/* sv/sbc_back.sv */
// Back end: schedule window, 64-round compression, chaining update and digest output.
module sbc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_entry_valid,
    input  sbc_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output sbc_pkg::t_word  o_digest_word,
    output logic [2:0]      o_digest_index,
    output logic            o_last_word
);
    import sbc_pkg::*;

    typedef enum logic [1:0] {ST_GATHER, ST_ROUND, ST_ADD, ST_EMIT} t_state;

    t_state     r_state;
    t_word      r_cv  [8];
    t_word      r_v   [8];
    t_word      r_win [BLOCK_WORDS];
    logic [5:0] r_round;
    logic       r_final;
    logic [2:0] r_emit_idx;
    logic       r_out_valid;
    t_word      r_out_word;
    logic [2:0] r_out_idx;
    logic       r_out_last;

    t_word t1;
    t_word t2;
    t_word ch;
    t_word maj;
    t_word w_next;
    logic  out_free;

    assign o_pop          = (r_state == ST_GATHER) && i_entry_valid;
    assign o_valid        = r_out_valid;
    assign o_digest_word  = r_out_word;
    assign o_digest_index = r_out_idx;
    assign o_last_word    = r_out_last;
    assign out_free       = !r_out_valid || !i_stall;

    always_comb begin
        ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1     = r_v[7] + big_s1(r_v[4]) + ch + ROUND_K[r_round] + r_win[0];
        t2     = big_s0(r_v[0]) + maj;
        w_next = small_s1(r_win[14]) + r_win[9] + small_s0(r_win[1]) + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_GATHER;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_cv[k] <= INIT_HASH[k];
            end
        end else begin
            if (r_out_valid && !i_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_GATHER: begin
                    if (i_entry_valid) begin
                        r_win[i_entry.idx] <= i_entry.word;
                        if (i_entry.start) begin
                            for (int k = 0; k < 8; k++) begin
                                r_cv[k] <= INIT_HASH[k];
                            end
                        end
                        if (i_entry.last) begin
                            for (int k = 0; k < 8; k++) begin
                                r_v[k] <= r_cv[k];
                            end
                            r_final <= i_entry.final_blk;
                            r_round <= '0;
                            r_state <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND: begin
                    for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                        r_win[k] <= r_win[k+1];
                    end
                    r_win[BLOCK_WORDS-1] <= w_next;
                    r_v[7]  <= r_v[6];
                    r_v[6]  <= r_v[5];
                    r_v[5]  <= r_v[4];
                    r_v[4]  <= r_v[3] + t1;
                    r_v[3]  <= r_v[2];
                    r_v[2]  <= r_v[1];
                    r_v[1]  <= r_v[0];
                    r_v[0]  <= t1 + t2;
                    r_round <= r_round + 6'd1;
                    if (&r_round) begin
                        r_state <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int k = 0; k < 8; k++) begin
                        r_cv[k] <= r_cv[k] + r_v[k];
                    end
                    r_emit_idx <= '0;
                    r_state    <= r_final ? ST_EMIT : ST_GATHER;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= r_cv[r_emit_idx];
                        r_out_idx   <= r_emit_idx;
                        r_out_last  <= &r_emit_idx;
                        r_emit_idx  <= r_emit_idx + 3'd1;
                        if (&r_emit_idx) begin
                            r_state <= ST_GATHER;
                        end
                    end
                end
                default: begin
                    r_state <= ST_GATHER;
                end
            endcase
        end
    end

endmodule

/* sv/sha256_block_compressor_unit.sv */
// SHA-256 block compressor: takes padded message words and returns the eight digest words.
//
// Input channel: i_valid with o_stall; a word is taken on a rising edge with i_valid high
// and o_stall low. Words arrive big-endian, sixteen to a block; i_start_message on a word
// reloads the initial hash and makes that word the first of a block; i_final_block on any
// word of a block marks the block as the message's last.
// Output channel: o_valid with i_stall; after a final block the eight digest words leave
// in order, index 0 (most significant) first, o_last_word set on index 7.
// Words pass through a four-entry queue into the compression engine. The engine takes one
// queued word per cycle while words are queued, then after the sixteenth runs one SHA-256
// round per cycle, then the chaining add. While the engine runs, the queue keeps taking
// words until it holds four. A final block adds the output of the eight digest words,
// one word per cycle when the receiver does not stall.
// Reset clears the queue, block position and output, and loads the initial hash. A stall
// on the output holds the current digest word; the engine waits while digest words remain
// to be loaded and goes back to taking words once the last one sits in the output register.
module sha256_block_compressor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_start_message,
    input  logic        i_final_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_digest_index,
    output logic        o_last_word
);
    import sbc_pkg::*;

    logic   entry_valid;
    t_entry entry;
    logic   pop;

    sbc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_message_word  (i_message_word),
        .i_start_message (i_start_message),
        .i_final_block   (i_final_block),
        .o_entry_valid   (entry_valid),
        .o_entry         (entry),
        .i_pop           (pop)
    );

    sbc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry_valid  (entry_valid),
        .i_entry        (entry),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_digest_index (o_digest_index),
        .o_last_word    (o_last_word)
    );

endmodule
